// ===== src/lddw_pkg.sv =====
// Package for the segment-LCD decimal digit writer.
// Holds the geometry constants, the segment code table and the reciprocal used for division by ten.
// It has no dependencies.
package lddw_pkg;

	// Number of display positions that are driven.
	localparam int NUM_POSITIONS = 6;

	// LCD image geometry: digit pairs per row and common rows.
	localparam int PAIRS = 3;
	localparam int ROWS  = 4;
	localparam int DEPTH = PAIRS * ROWS;

	// Field widths.
	localparam int VAL_W = 20;
	localparam int DIG_W = 4;
	localparam int POS_W = 3;
	localparam int ROW_W = 2;
	localparam int IDX_W = 4;
	localparam int OFF_W = 5;
	localparam int BYTE_W = 8;

	// Request types.
	localparam logic REQ_NUMBER = 1'b0;
	localparam logic REQ_DIGIT  = 1'b1;

	// Division by ten as ceil(2^23 / 10); the quotient is exact for any 20-bit value.
	localparam int          DIV10_SHIFT = 23;
	localparam logic [VAL_W-1:0] DIV10_MUL = 20'd838861;

	// Sixteen-bit segment code of a decimal digit; one nibble for each row, row 0 lowest.
	function automatic logic [15:0] seg_code(input logic [DIG_W-1:0] d);
		logic [15:0] code;
		unique case (d)
			4'd0: code = 16'h1551;
			4'd1: code = 16'h0110;
			4'd2: code = 16'h1E11;
			4'd3: code = 16'h1B11;
			4'd4: code = 16'h0B50;
			4'd5: code = 16'h1B41;
			4'd6: code = 16'h1F41;
			4'd7: code = 16'h0111;
			4'd8: code = 16'h1F51;
			4'd9: code = 16'h0B51;
			default: code = 16'h0000;
		endcase
		return code;
	endfunction

endpackage

// ===== src/lcd_decimal_digit_writer.sv =====
// Segment-LCD decimal digit writer: keeps the twelve-byte LCD image in a synchronous memory.
// Depends on lddw_pkg. Each step passes through the read stage and then the output register.
// A number request takes 24 memory read-modify-write steps, one a cycle while the output is not
// stalled, and a digit request one step for each row; in_ready stays low until the last step of a
// request is issued. An out-of-range digit request is accepted but gives no beat.
// Reset (arst_n low) clears the image to zero through per-entry valid bits, at once.
module lcd_decimal_digit_writer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          req_type,
	input  logic [lddw_pkg::VAL_W-1:0]    value,
	input  logic [lddw_pkg::DIG_W-1:0]    digit,
	input  logic [lddw_pkg::POS_W-1:0]    digit_pos,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lddw_pkg::OFF_W-1:0]    reg_offset,
	output logic [lddw_pkg::BYTE_W-1:0]   reg_data,
	output logic                          last
);
	import lddw_pkg::*;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_POSITIONS - 1);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

	// Sequencer state.
	logic                 busy_q;
	logic                 mode_q;
	logic [VAL_W-1:0]     val_q;
	logic [DIG_W-1:0]     dig_q;
	logic [POS_W-1:0]     pos_q;
	logic [ROW_W-1:0]     row_q;

	// Read stage.
	logic                 v_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [OFF_W-1:0]     off_s1;
	logic [3:0]           nib_s1;
	logic                 odd_s1;
	logic                 last_s1;
	logic                 vld_s1;
	logic                 fwd_s1;
	logic [BYTE_W-1:0]    fwd_data_s1;

	// Memory and its valid bits.
	logic [BYTE_W-1:0]    mem [DEPTH];
	logic [BYTE_W-1:0]    rd_q;
	logic [DEPTH-1:0]     ent_vld_q;

	// Output register.
	logic                 out_valid_q;
	logic [OFF_W-1:0]     off_q;
	logic [BYTE_W-1:0]    data_q;
	logic                 last_q;

	logic                 accept;
	logic                 s1_go;
	logic                 issue;
	logic                 step_last;
	logic [2*VAL_W-1:0]   prod;
	logic [VAL_W-1:0]     quot;
	logic [VAL_W-1:0]     rem_full;
	logic [DIG_W-1:0]     cur_dig;
	logic [15:0]          code;
	logic [1:0]           pair;
	logic [IDX_W-1:0]     rd_idx;
	logic [OFF_W-1:0]     rd_off;
	logic [BYTE_W-1:0]    old_byte;
	logic [BYTE_W-1:0]    new_byte;
	logic                 dig_ok;

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;
	assign dig_ok   = (digit <= DIG_W'(9)) && (digit_pos <= LAST_POS);

	// Handshake between the read stage and the output register.
	assign s1_go = v_s1 && (!out_valid_q || out_ready);
	assign issue = busy_q && (!v_s1 || s1_go);

	// Lowest decimal digit of the running value through a reciprocal multiply.
	assign prod     = (2*VAL_W)'(val_q) * (2*VAL_W)'(DIV10_MUL);
	assign quot     = VAL_W'(prod >> DIV10_SHIFT);
	assign rem_full = val_q - ((quot << 3) + (quot << 1));
	assign cur_dig  = (mode_q == REQ_NUMBER) ? rem_full[DIG_W-1:0] : dig_q;

	// Address and segment nibble of the current step.
	assign code   = seg_code(cur_dig);
	assign pair   = pos_q[POS_W-1:1];
	assign rd_idx = IDX_W'({row_q, 1'b0}) + IDX_W'(row_q) + IDX_W'(pair);
	assign rd_off = OFF_W'({row_q, 2'b00}) + OFF_W'(row_q) + OFF_W'(pair);
	assign step_last = (row_q == LAST_ROW) &&
		((mode_q == REQ_DIGIT) || (pos_q == '0));

	// Merge the nibble into the old byte, with the write of the same cycle forwarded.
	always_comb begin
		if (fwd_s1) begin
			old_byte = fwd_data_s1;
		end else if (vld_s1) begin
			old_byte = rd_q;
		end else begin
			old_byte = '0;
		end
		if (odd_s1) begin
			new_byte = {nib_s1, old_byte[3:0]};
		end else begin
			new_byte = {old_byte[7:4], nib_s1};
		end
	end

	// Sequencer: one row of one digit per issued step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= (req_type == REQ_NUMBER) || dig_ok;
		end else if (issue && step_last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= req_type;
			val_q  <= value;
			dig_q  <= digit;
			row_q  <= '0;
			if (req_type == REQ_NUMBER) begin
				pos_q <= LAST_POS;
			end else begin
				pos_q <= digit_pos;
			end
		end else if (issue) begin
			row_q <= row_q + 1'b1;
			if (row_q == LAST_ROW) begin
				val_q <= quot;
				pos_q <= pos_q - 1'b1;
			end
		end
	end

	// Read stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (issue) begin
			v_s1 <= 1'b1;
		end else if (s1_go) begin
			v_s1 <= 1'b0;
		end
	end

	// Read stage payload, including the valid bit and a same-cycle forward.
	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1      <= rd_idx;
			off_s1      <= rd_off;
			nib_s1      <= code[4*row_q +: 4];
			odd_s1      <= pos_q[0];
			last_s1     <= step_last;
			vld_s1      <= ent_vld_q[rd_idx];
			fwd_s1      <= s1_go && (idx_s1 == rd_idx);
			fwd_data_s1 <= new_byte;
		end
	end

	// Image memory: one read and one write port, read data registered.
	always_ff @(posedge clk) begin
		if (s1_go) begin
			mem[idx_s1] <= new_byte;
		end
		if (issue) begin
			rd_q <= mem[rd_idx];
		end
	end

	// Entries read as zero until first written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (s1_go) begin
			ent_vld_q[idx_s1] <= 1'b1;
		end
	end

	// Output register holds each result beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			off_q  <= off_s1;
			data_q <= new_byte;
			last_q <= last_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign reg_offset = off_q;
	assign reg_data   = data_q;
	assign last       = last_q;

endmodule

// ===== tb/sv/lcd_decimal_digit_writer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the segment-LCD decimal digit writer.
// Depends on lddw_pkg and lcd_decimal_digit_writer; a shadow LCD image predicts every
// register write.
module lcd_decimal_digit_writer_tb;
	import lddw_pkg::*;

	// Segment patterns of the digits 0 to 9, digit 0 in the lowest sixteen bits.
	localparam logic [10*16-1:0] SEGMENT_PATTERNS = {
		16'h0B51, 16'h1F51, 16'h0111, 16'h1F41, 16'h1B41,
		16'h0B50, 16'h1B11, 16'h1E11, 16'h0110, 16'h1551
	};
	localparam int SETTLE_CYCLES = 30;

	typedef struct packed {
		logic [OFF_W-1:0]  offset;
		logic [BYTE_W-1:0] data;
		logic              last;
	} lcd_write_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               req_type = REQ_NUMBER;
	logic [VAL_W-1:0]   value = '0;
	logic [DIG_W-1:0]   digit = '0;
	logic [POS_W-1:0]   digit_pos = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [OFF_W-1:0]   reg_offset;
	logic [BYTE_W-1:0]  reg_data;
	logic               last;

	// Shadow copy of the LCD image and the register writes still to come.
	logic [BYTE_W-1:0]  shadow_image [DEPTH];
	lcd_write_t         pending_writes [$];

	int send_gap_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int number_reqs = 0;
	int digit_reqs = 0;
	int ignored_reqs = 0;
	int beats_checked = 0;

	lcd_decimal_digit_writer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.value      (value),
		.digit      (digit),
		.digit_pos  (digit_pos),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.reg_offset (reg_offset),
		.reg_data   (reg_data),
		.last       (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Writes one digit into the shadow image and queues the four register writes it causes.
	function automatic int shadow_put_digit(int unsigned d, int unsigned pos);
		logic [15:0] pattern;
		logic [3:0]  nib;
		int          pair;
		int          idx;
		if (d > 9 || pos >= NUM_POSITIONS)
			return 0;
		pattern = SEGMENT_PATTERNS[d*16 +: 16];
		pair = pos / 2;
		for (int row = 0; row < ROWS; row++) begin
			nib = pattern[row*4 +: 4];
			idx = row * PAIRS + pair;
			if (pos % 2)
				shadow_image[idx] = {nib, shadow_image[idx][3:0]};
			else
				shadow_image[idx] = {shadow_image[idx][7:4], nib};
			pending_writes.push_back('{offset: OFF_W'(pair + 5 * row),
				data: shadow_image[idx], last: 1'b0});
		end
		return ROWS;
	endfunction

	// Predicts the writes of one accepted request; returns how many beats it gives.
	function automatic int predict_lcd_writes(logic rtype, logic [VAL_W-1:0] val,
			logic [DIG_W-1:0] d, logic [POS_W-1:0] pos);
		int unsigned rest;
		int          beats;
		beats = 0;
		if (rtype == REQ_NUMBER) begin
			rest = val;
			for (int n = NUM_POSITIONS - 1; n >= 0; n--) begin
				beats += shadow_put_digit(rest % 10, n);
				rest = rest / 10;
			end
		end else begin
			beats = shadow_put_digit(d, pos);
		end
		if (beats > 0)
			pending_writes[pending_writes.size() - 1].last = 1'b1;
		return beats;
	endfunction

	// Sends one request, sometimes after a random gap, and predicts it once accepted.
	task automatic send_request(input logic rtype, input logic [VAL_W-1:0] val,
			input logic [DIG_W-1:0] d, input logic [POS_W-1:0] pos, output int beats);
		if ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rtype;
		value <= val;
		digit <= d;
		digit_pos <= pos;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
		beats = predict_lcd_writes(rtype, val, d, pos);
		if (rtype == REQ_NUMBER)
			number_reqs++;
		else
			digit_reqs++;
		if (beats == 0)
			ignored_reqs++;
	endtask

	// Holds the sender back until every predicted write has come out, then lets it settle.
	task automatic wait_until_drained();
		in_valid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Receiver: checks each result beat against the oldest prediction, then picks ready.
	always @(posedge clk) begin
		lcd_write_t want;
		if (out_valid && out_ready) begin
			beats_checked++;
			if (pending_writes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected beat offset=%0d data=%02h last=%0b",
						$realtime, reg_offset, reg_data, last);
			end else begin
				want = pending_writes.pop_front();
				if (reg_offset !== want.offset || reg_data !== want.data ||
						last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: expected offset=%0d data=%02h last=%0b, got %0d %02h %0b",
							$realtime, want.offset, want.data, want.last,
							reg_offset, reg_data, last);
				end
			end
		end
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Whole numbers at the edges of the field, including ones too large to show in full.
	task automatic test_number_edges();
		int beats;
		send_request(REQ_NUMBER, 20'd0, 4'd15, 3'd7, beats);
		send_request(REQ_NUMBER, 20'd999999, 4'd0, 3'd0, beats);
		send_request(REQ_NUMBER, 20'd123456, 4'd9, 3'd5, beats);
		send_request(REQ_NUMBER, 20'hFFFFF, 4'd8, 3'd2, beats);
		send_request(REQ_NUMBER, 20'd1000000, 4'd3, 3'd4, beats);
	endtask

	// Every digit once, at even and odd positions in turn, then rejected digits and positions.
	task automatic test_single_digits();
		int beats;
		for (int d = 0; d < 10; d++)
			send_request(REQ_DIGIT, VAL_W'($urandom), DIG_W'(d), POS_W'(d % NUM_POSITIONS),
				beats);
		send_request(REQ_DIGIT, 20'hFFFFF, 4'd10, 3'd1, beats);
		send_request(REQ_DIGIT, 20'h00000, 4'd15, 3'd2, beats);
		send_request(REQ_DIGIT, 20'h5A5A5, 4'd4, 3'd6, beats);
		send_request(REQ_DIGIT, 20'hA5A5A, 4'd7, 3'd7, beats);
		// Writing the same digit twice leaves the bytes unchanged but still gives beats.
		send_request(REQ_DIGIT, 20'd0, 4'd7, 3'd3, beats);
		send_request(REQ_DIGIT, 20'd0, 4'd7, 3'd3, beats);
	endtask

	// Random mix of requests under one idling setting; ignored requests are not counted.
	task automatic test_random_phase(input int items, input int gap_pct, input int stall);
		int          made;
		int          beats;
		int          pick;
		logic        rtype;
		logic [VAL_W-1:0] val;
		logic [DIG_W-1:0] d;
		logic [POS_W-1:0] pos;
		send_gap_pct = gap_pct;
		stall_pct = stall;
		made = 0;
		while (made < items) begin
			pick = $urandom_range(99);
			val = VAL_W'($urandom);
			d = DIG_W'($urandom);
			pos = POS_W'($urandom);
			if (pick < 40) begin
				rtype = REQ_NUMBER;
				val = VAL_W'($urandom_range(999999));
			end else if (pick < 50) begin
				rtype = REQ_NUMBER;
			end else if (pick < 90) begin
				rtype = REQ_DIGIT;
				d = DIG_W'($urandom_range(9));
				pos = POS_W'($urandom_range(NUM_POSITIONS - 1));
			end else begin
				rtype = REQ_DIGIT;
			end
			send_request(rtype, val, d, pos, beats);
			if (beats > 0)
				made++;
			// Halfway through, the sender stops until everything has come out.
			if (made == items / 2 && beats > 0)
				wait_until_drained();
		end
		wait_until_drained();
	endtask

	initial begin
		for (int i = 0; i < DEPTH; i++)
			shadow_image[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_number_edges();
		test_single_digits();
		wait_until_drained();
		test_random_phase(25, 0, 0);
		test_random_phase(25, 45, 0);
		test_random_phase(25, 0, 45);
		test_random_phase(25, 35, 35);
		mismatches += pending_writes.size();
		$display("Ran %0d number and %0d digit requests (%0d ignored), %0d beats checked,",
			number_reqs, digit_reqs, ignored_reqs, beats_checked);
		$display("across runs with no idling, sender gaps, receiver stalls and both.");
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog: far longer than the slowest correct run.
	initial begin
		#5_000_000;
		$display("Run timed out with %0d writes outstanding.", pending_writes.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
